@@ rtl/core/bla_pkg.sv @@
package bla_pkg;

  localparam int SUM_W   = 18;
  localparam int RAW_W   = 12;
  localparam int MV_W    = 16;
  localparam int PCT_W   = 8;
  localparam int GAIN_W  = 20;
  localparam int OFS_W   = 12;
  localparam int DEN_W   = 8;
  localparam int CFG_W   = 20;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_CNV = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_GAIN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_OFFSET = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_RESET   = 20'd53000;
  localparam logic [OFS_W-1:0]  OFFSET_RESET = 12'd142;
  localparam logic [RAW_W-1:0]  RAW_LOW_LIMIT = 12'd16;
  localparam logic [PCT_W-1:0]  INVALID_PCT   = 8'd255;
  localparam logic [31:0]       ROUND_HALF    = 32'd32768;

  localparam int CURVE_POINTS = 11;
  localparam logic [12:0] CURVE_MV [CURVE_POINTS] = '{
    13'd4200, 13'd4100, 13'd4000, 13'd3920, 13'd3850, 13'd3790,
    13'd3730, 13'd3680, 13'd3600, 13'd3500, 13'd3300};
  localparam logic [6:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
    7'd40, 7'd30, 7'd20, 7'd10, 7'd0};

  typedef struct packed {
    logic [RAW_W-1:0] raw_sample;
    logic             read_ok;
  } sample_t;

  typedef struct packed {
    logic             success;
    logic [MV_W-1:0]  adc_millivolts;
    logic [MV_W-1:0]  battery_millivolts;
    logic [PCT_W-1:0] charge_percent;
    logic             reading_present;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] numer;
    logic [DEN_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/core/bla_div.sv @@
module bla_div (
  input  logic            clk,
  input  logic            rst,
  input  bla_pkg::div_req_t req,
  output bla_pkg::div_rsp_t rsp
);
  import bla_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] step;
  logic [DEN_W-1:0] denom;
  logic [DEN_W-1:0] rem;
  logic [SUM_W-1:0] quo;
  logic [DEN_W:0]   trial;
  logic             fits;

  // One restoring step per cycle: the numerator shifts out of quo while the
  // quotient bits shift in behind it.
  assign trial = {rem, quo[SUM_W-1]};
  assign fits  = trial >= {1'b0, denom};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        step  <= '0;
        quo   <= req.numer;
        rem   <= '0;
        denom <= req.denom;
      end else if (busy) begin
        rem  <= fits ? DEN_W'(trial - {1'b0, denom}) : DEN_W'(trial);
        quo  <= {quo[SUM_W-2:0], fits};
        step <= step + 1'b1;
        if (step == CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

@@ rtl/core/battery_level_averager.sv @@
// Requests inside a burst are taken back to back; the last of SAMPLES_PER_READING requests
// yields one result after two passes of the shared bit-serial divider (average and
// interpolation); at or beyond a curve end the interpolation pass is skipped, an empty
// burst skips both, and sample_ready stays low until the result is presented. A result
// still waiting to be taken holds the next one back. Synchronous active-high reset
// restores the default calibration, disables the block and marks the percent invalid.
module battery_level_averager #(
  parameter int SAMPLES_PER_READING = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bla_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bla_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  bla_pkg::sample_t                sample,
  output logic                            result_valid,
  input  logic                            result_ready,
  output bla_pkg::result_t                result
);
  import bla_pkg::*;

  localparam int CW = $clog2(SAMPLES_PER_READING + 1);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_DIV_AVG = 7'b0000010,
    ST_CAL     = 7'b0000100,
    ST_BAT     = 7'b0001000,
    ST_PCT     = 7'b0010000,
    ST_DIV_PCT = 7'b0100000,
    ST_FINISH  = 7'b1000000
  } state_t;

  state_t state;

  logic              enable;
  logic              second_converter;
  logic [GAIN_W-1:0] cal_gain;
  logic [OFS_W-1:0]  cal_offset;

  logic [SUM_W-1:0]  sample_sum;
  logic [CW-1:0]     valid_count;
  logic [CW-1:0]     attempt_count;
  logic              have_reading;
  logic [MV_W-1:0]   held_adc_mv;
  logic [MV_W-1:0]   held_battery_mv;
  logic [PCT_W-1:0]  held_percent;
  logic              success;
  logic [31:0]       product;
  logic [6:0]        pct_base;

  logic              accept;
  logic              keep;
  logic [SUM_W-1:0]  sample_sum_next;
  logic [CW-1:0]     valid_count_next;
  logic [CW-1:0]     attempt_count_next;
  logic              burst_end;

  logic [32:0]       rounded;
  logic [MV_W:0]     mv_sum;
  logic [MV_W+1:0]   bat_sum;

  logic              seg_found;
  logic [6:0]        seg_base;
  logic [3:0]        seg_range;
  logic [7:0]        seg_span;
  logic [7:0]        seg_diff;
  logic [11:0]       seg_numer;

  div_req_t div_req;
  div_rsp_t div_rsp;

  bla_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign sample_ready = (state == ST_IDLE);
  assign accept       = sample_valid && sample_ready && enable;

  assign keep = sample.read_ok &&
                !(second_converter && have_reading && sample.raw_sample <= RAW_LOW_LIMIT);
  assign sample_sum_next    = keep ? sample_sum + SUM_W'(sample.raw_sample) : sample_sum;
  assign valid_count_next   = keep ? valid_count + 1'b1 : valid_count;
  assign attempt_count_next = attempt_count + 1'b1;
  assign burst_end          = attempt_count_next >= CW'(SAMPLES_PER_READING);

  // Calibration: round the Q16 product, add the offset, then saturate.
  assign rounded = {1'b0, product} + {1'b0, ROUND_HALF};
  assign mv_sum  = rounded[32:16] + (MV_W+1)'(cal_offset);
  assign bat_sum = {1'b0, held_adc_mv, 1'b0} + (MV_W+2)'(held_adc_mv);

  // The curve falls monotonically, so the first point at or below the
  // voltage closes the segment that holds it.
  always_comb begin
    seg_found = 1'b0;
    seg_base  = '0;
    seg_range = '0;
    seg_span  = 8'd1;
    seg_diff  = '0;
    for (int i = 0; i < CURVE_POINTS - 1; i++) begin
      if (!seg_found && held_battery_mv >= MV_W'(CURVE_MV[i+1])) begin
        seg_found = 1'b1;
        seg_base  = CURVE_PCT[i+1];
        seg_range = 4'(CURVE_PCT[i] - CURVE_PCT[i+1]);
        seg_span  = 8'(CURVE_MV[i] - CURVE_MV[i+1]);
        seg_diff  = 8'(held_battery_mv - MV_W'(CURVE_MV[i+1]));
      end
    end
    seg_numer = 12'(seg_diff) * 12'(seg_range);
  end

  always_comb begin
    div_req = '0;
    if (state == ST_IDLE) begin
      div_req.start = accept && burst_end && (valid_count_next != '0);
      div_req.numer = sample_sum_next;
      div_req.denom = DEN_W'(valid_count_next);
    end else if (state == ST_PCT) begin
      div_req.start = (held_battery_mv < MV_W'(CURVE_MV[0])) &&
                      (held_battery_mv > MV_W'(CURVE_MV[CURVE_POINTS-1]));
      div_req.numer = SUM_W'(seg_numer);
      div_req.denom = seg_span;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      enable           <= 1'b0;
      second_converter <= 1'b0;
      cal_gain         <= GAIN_RESET;
      cal_offset       <= OFFSET_RESET;
      sample_sum       <= '0;
      valid_count      <= '0;
      attempt_count    <= '0;
      have_reading     <= 1'b0;
      held_adc_mv      <= '0;
      held_battery_mv  <= '0;
      held_percent     <= INVALID_PCT;
      success          <= 1'b0;
      result_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE: begin
            if (!enable && cfg_data[0]) begin
              have_reading  <= 1'b0;
              held_percent  <= INVALID_PCT;
              sample_sum    <= '0;
              valid_count   <= '0;
              attempt_count <= '0;
            end
            enable <= cfg_data[0];
          end
          CFG_SECOND_CNV: second_converter <= cfg_data[0];
          CFG_CAL_GAIN:   cal_gain         <= cfg_data[GAIN_W-1:0];
          CFG_CAL_OFFSET: cal_offset       <= cfg_data[OFS_W-1:0];
          default: ;
        endcase
      end

      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (burst_end) begin
              sample_sum    <= '0;
              valid_count   <= '0;
              attempt_count <= '0;
              if (valid_count_next != '0) begin
                state <= ST_DIV_AVG;
              end else begin
                success <= 1'b0;
                state   <= ST_FINISH;
              end
            end else begin
              sample_sum    <= sample_sum_next;
              valid_count   <= valid_count_next;
              attempt_count <= attempt_count_next;
            end
          end
        end
        ST_DIV_AVG: begin
          if (div_rsp.done) begin
            product <= 32'(div_rsp.quotient[RAW_W-1:0]) * 32'(cal_gain);
            state   <= ST_CAL;
          end
        end
        ST_CAL: begin
          held_adc_mv <= mv_sum[MV_W] ? '1 : mv_sum[MV_W-1:0];
          state       <= ST_BAT;
        end
        ST_BAT: begin
          held_battery_mv <= (bat_sum[MV_W+1:MV_W] != '0) ? '1 : bat_sum[MV_W-1:0];
          state           <= ST_PCT;
        end
        ST_PCT: begin
          pct_base <= seg_base;
          if (div_req.start) begin
            state <= ST_DIV_PCT;
          end else begin
            held_percent <= (held_battery_mv >= MV_W'(CURVE_MV[0])) ?
                            PCT_W'(CURVE_PCT[0]) : PCT_W'(CURVE_PCT[CURVE_POINTS-1]);
            have_reading <= 1'b1;
            success      <= 1'b1;
            state        <= ST_FINISH;
          end
        end
        ST_DIV_PCT: begin
          if (div_rsp.done) begin
            held_percent <= PCT_W'(pct_base + div_rsp.quotient[6:0]);
            have_reading <= 1'b1;
            success      <= 1'b1;
            state        <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!result_valid || result_ready)) begin
      result.success            <= success;
      result.adc_millivolts     <= held_adc_mv;
      result.battery_millivolts <= held_battery_mv;
      result.charge_percent     <= held_percent;
      result.reading_present    <= have_reading;
    end
  end

endmodule

@@ rtl/core/bla_checker.sv @@
module bla_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input bla_pkg::result_t result
);
  import bla_pkg::*;

  logic [MV_W+1:0] bat_expect;
  assign bat_expect = {1'b0, result.adc_millivolts, 1'b0} + (MV_W+2)'(result.adc_millivolts);

  // A stalled result must hold.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.success |-> result.reading_present)
    else $error("success without a reading");

  // Without a reading the percent reads as invalid; with one it is in range.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.reading_present |-> result.charge_percent == INVALID_PCT)
    else $error("percent valid without a reading");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.reading_present |-> result.charge_percent <= 8'd100)
    else $error("percent out of range");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.success |->
      (result.battery_millivolts == 16'hFFFF && bat_expect > 18'd65535) ||
      (18'(result.battery_millivolts) == bat_expect))
    else $error("battery voltage does not match the divider ratio");

endmodule

bind battery_level_averager bla_checker u_bla_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import bla_pkg::*;

  localparam int BURST_LEN = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_TARGET = 450;

  typedef enum int {FILL_EMPTY, FILL_CURVE, FILL_LOW, FILL_WIDE} fill_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic sample_valid = 1'b0;
  logic sample_ready;
  sample_t sample = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;

  battery_level_averager #(
    .SAMPLES_PER_READING(BURST_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always #5 clk = ~clk;

  // Discharge curve knees, highest voltage first.
  int knee_mv [0:10] = '{4200, 4100, 4000, 3920, 3850, 3790, 3730, 3680, 3600, 3500, 3300};
  int knee_pct [0:10] = '{100, 90, 80, 70, 60, 50, 40, 30, 20, 10, 0};

  // Predicted configuration and averaging state.
  logic en_q = 1'b0;
  logic second_q = 1'b0;
  logic [GAIN_W-1:0] gain_q = 20'd53000;
  logic [OFS_W-1:0] offset_q = 12'd142;
  logic [SUM_W-1:0] burst_sum = '0;
  logic [6:0] kept_count = '0;
  int attempts = 0;
  logic have_reading = 1'b0;
  logic [MV_W-1:0] held_adc = '0;
  logic [MV_W-1:0] held_bat = '0;
  logic [PCT_W-1:0] held_pct = 8'd255;

  sample_t pending_samples[$];
  result_t expected_readings[$];
  int errors = 0;
  int readings_seen = 0;
  int item_total = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit held_once = 1'b0;
  bit steady = 1'b0;

  function automatic logic [PCT_W-1:0] charge_from_mv(input logic [MV_W-1:0] mv);
    int m;
    m = mv;
    if (m >= knee_mv[0]) return 8'd100;
    if (m <= knee_mv[10]) return 8'd0;
    for (int i = 0; i < 10; i++) begin
      if (m <= knee_mv[i] && m >= knee_mv[i+1])
        return PCT_W'(knee_pct[i+1] +
                      ((m - knee_mv[i+1]) * (knee_pct[i] - knee_pct[i+1])) /
                      (knee_mv[i] - knee_mv[i+1]));
    end
    return 8'd0;
  endfunction

  function automatic void account_sample(input sample_t s);
    logic [63:0] avg;
    logic [63:0] mv;
    logic [63:0] bat;
    result_t r;
    if (!en_q) return;
    if (s.read_ok && !(second_q && have_reading && s.raw_sample <= 12'd16)) begin
      burst_sum = burst_sum + SUM_W'(s.raw_sample);
      kept_count = kept_count + 7'd1;
    end
    attempts++;
    if (attempts < BURST_LEN) return;
    r.success = 1'b0;
    if (kept_count != 0) begin
      avg = burst_sum / kept_count;
      mv = ((avg * gain_q + 64'd32768) >> 16) + offset_q;
      if (mv > 64'd65535) mv = 64'd65535;
      bat = mv * 3;
      if (bat > 64'd65535) bat = 64'd65535;
      held_adc = mv[15:0];
      held_bat = bat[15:0];
      held_pct = charge_from_mv(held_bat);
      have_reading = 1'b1;
      r.success = 1'b1;
    end
    burst_sum = '0;
    kept_count = '0;
    attempts = 0;
    r.adc_millivolts = held_adc;
    r.battery_millivolts = held_bat;
    r.charge_percent = held_pct;
    r.reading_present = have_reading;
    expected_readings.push_back(r);
  endfunction

  function automatic bit take_gap();
    return !steady && ($urandom_range(99) < 32);
  endfunction

  // Request driver: a new request goes out once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && sample_ready) account_sample(sample);
      if (!sample_valid || sample_ready) begin
        if (pending_samples.size() != 0 && !take_gap()) begin
          sample <= pending_samples.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Result acceptor, with one long hold-off so that the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else if (readings_seen == 3 && !held_once) begin
      held_once <= 1'b1;
      hold_left <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else begin
      result_ready <= !take_gap();
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      readings_seen <= readings_seen + 1;
      if (expected_readings.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: s=%0d adc=%0d bat=%0d pct=%0d rp=%0d",
                   result.success, result.adc_millivolts, result.battery_millivolts,
                   result.charge_percent, result.reading_present);
      end else begin
        want = expected_readings.pop_front();
        if (result.success !== want.success ||
            result.adc_millivolts !== want.adc_millivolts ||
            result.battery_millivolts !== want.battery_millivolts ||
            result.charge_percent !== want.charge_percent ||
            result.reading_present !== want.reading_present) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected s=%0d adc=%0d bat=%0d pct=%0d rp=%0d",
                     want.success, want.adc_millivolts, want.battery_millivolts,
                     want.charge_percent, want.reading_present);
            $display("          got      s=%0d adc=%0d bat=%0d pct=%0d rp=%0d",
                     result.success, result.adc_millivolts, result.battery_millivolts,
                     result.charge_percent, result.reading_present);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (sample_valid && sample_ready) || (result_valid && result_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_ENABLE: begin
        if (!en_q && data[0]) begin
          have_reading = 1'b0;
          held_pct = 8'd255;
          burst_sum = '0;
          kept_count = '0;
          attempts = 0;
        end
        en_q = data[0];
      end
      CFG_SECOND_CNV: second_q = data[0];
      CFG_CAL_GAIN: gain_q = data[GAIN_W-1:0];
      CFG_CAL_OFFSET: offset_q = data[OFS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained(input int tail);
    while (pending_samples.size() != 0 || sample_valid || expected_readings.size() != 0)
      @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic push_sample(input logic [RAW_W-1:0] raw, input logic ok);
    sample_t s;
    s.raw_sample = raw;
    s.read_ok = ok;
    pending_samples.push_back(s);
    item_total++;
  endtask

  // Fills a run of requests; centre picks where the average lands on the curve.
  task automatic add_items(input int n, input fill_t fill);
    int centre;
    centre = $urandom_range(1600, 1150);
    for (int i = 0; i < n; i++) begin
      case (fill)
        FILL_EMPTY: push_sample(RAW_W'($urandom), 1'b0);
        FILL_CURVE: push_sample(RAW_W'(centre + $urandom_range(30) - 15),
                                $urandom_range(9) != 0);
        FILL_LOW: begin
          if ($urandom_range(3) == 0)
            push_sample(RAW_W'(centre + $urandom_range(30) - 15), 1'b1);
          else
            push_sample(RAW_W'($urandom_range(24)), $urandom_range(9) != 0);
        end
        default: push_sample(RAW_W'($urandom), 1'($urandom));
      endcase
    end
  endtask

  function automatic fill_t pick_fill(input bit low_bias);
    int roll;
    roll = $urandom_range(99);
    if (low_bias && roll < 40) return FILL_LOW;
    if (roll < 10) return FILL_EMPTY;
    if (roll < 65) return FILL_CURVE;
    if (roll < 80) return FILL_LOW;
    return FILL_WIDE;
  endfunction

  task automatic add_bursts(input int n, input bit low_bias);
    for (int b = 0; b < n; b++) add_items(BURST_LEN, pick_fill(low_bias));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Requests while disabled must leave no trace.
    push_sample(12'd4095, 1'b1);
    push_sample(12'd0, 1'b1);
    push_sample(12'd1300, 1'b0);
    wait_drained(DRAIN_CYCLES);
    write_reg(CFG_ENABLE, 20'd1);

    // Extremes of the sample fields and failed reads, with the low-sample filter still off.
    push_sample(12'd0, 1'b1);
    push_sample(12'd4095, 1'b1);
    push_sample(12'd16, 1'b1);
    push_sample(12'd17, 1'b1);
    push_sample(12'd4095, 1'b0);
    push_sample(12'd0, 1'b0);
    for (int i = 0; i < 10; i++) push_sample(RAW_W'(1300 + i), 1'b1);
    add_bursts(4, 1'b0);
    wait_drained(DRAIN_CYCLES);

    steady = 1'b1;
    write_reg(CFG_SECOND_CNV, 20'd1);
    add_bursts(4, 1'b1);
    wait_drained(DRAIN_CYCLES);
    steady = 1'b0;

    // Full-scale calibration, under which high averages saturate the voltages.
    write_reg(CFG_CAL_GAIN, 20'hFFFFF);
    write_reg(CFG_CAL_OFFSET, 20'hFFF);
    add_bursts(2, 1'b0);
    wait_drained(DRAIN_CYCLES);

    write_reg(CFG_CAL_GAIN, 20'd0);
    write_reg(CFG_CAL_OFFSET, 20'd0);
    add_bursts(2, 1'b0);
    wait_drained(DRAIN_CYCLES);

    // A partial burst, then a disable and re-enable that drops it and the reading.
    write_reg(CFG_CAL_GAIN, 20'd53000);
    write_reg(CFG_CAL_OFFSET, 20'd142);
    add_items(7, FILL_CURVE);
    wait_drained(DRAIN_CYCLES);
    write_reg(CFG_ENABLE, 20'd0);
    add_items(3, FILL_WIDE);
    wait_drained(DRAIN_CYCLES);
    write_reg(CFG_ENABLE, 20'd1);
    add_items(BURST_LEN, FILL_LOW);
    add_bursts(2, 1'b1);
    wait_drained(DRAIN_CYCLES);

    while (item_total < ITEM_TARGET) begin
      write_reg(CFG_CAL_GAIN,
                CFG_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(62000, 45000)));
      write_reg(CFG_CAL_OFFSET,
                CFG_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(300)));
      write_reg(CFG_SECOND_CNV, CFG_W'($urandom_range(1)));
      add_bursts(3, 1'($urandom_range(1)));
      wait_drained(DRAIN_CYCLES);
    end

    wait_drained(100);
    if (errors == 0 && expected_readings.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ battery_level_averager.f @@
rtl/core/bla_pkg.sv
rtl/core/bla_div.sv
rtl/core/battery_level_averager.sv
rtl/core/bla_checker.sv
test/tb_top.sv
